// ----- hw/rtl/lca_pkg.sv -----
package lca_pkg;

  localparam int MAX_CLASSES_DEF  = 16;
  localparam int MAX_FEATURES_DEF = 256;

  localparam int CLASS_W  = 4;
  localparam int FEAT_W   = 8;
  localparam int VALUE_W  = 16;
  localparam int PROD_W   = 2 * VALUE_W;
  localparam int SUM_W    = 48;
  localparam int CNT_W    = 20;
  localparam int NCLS_W   = 5;

  localparam logic [NCLS_W-1:0] NUM_CLASSES_RESET = NCLS_W'(10);

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 48;

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

endpackage

// ----- hw/rtl/lca_ram.sv -----
module lca_ram
  #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
  )
  (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
  );

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/lca_mac.sv -----
module lca_mac
  import lca_pkg::*;
  (
    input  logic                      clk,
    input  logic                      en,
    input  logic signed [VALUE_W-1:0] weight,
    input  logic signed [VALUE_W-1:0] feature,
    input  logic signed [SUM_W-1:0]   sum_in,
    output logic signed [SUM_W-1:0]   sum_out
  );

  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  acc;
  logic signed [SUM_W:0]    wide;

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= weight * feature;
      acc  <= sum_in;
    end
  end

  // exact add, then clamp to the signed accumulator range
  assign wide = (SUM_W+1)'(acc) + (SUM_W+1)'(prod);

  always_comb begin
    if (wide[SUM_W] != wide[SUM_W-1]) begin
      sum_out = wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_out = wide[SUM_W-1:0];
    end
  end

endmodule

// ----- hw/rtl/linear_classifier_accuracy.sv -----
// channel  | dir | tdata (low bit up)                             | tuser  | tlast
// s_axis   | in  | class_index, feature_index, value, label       | action | last_feature
// m_axis   | out | predicted_class, is_correct, correct_count,    | -      | -
//          |     | sample_count, zero pad                          |        |
// cfg      | in  | num_classes on cfg_wdata when cfg_wen           | -      | -
//
// a weight load writes the weight ram; a feature value runs one multiply-accumulate
// per active class on the shared mac unit, then drains the mac pipeline
// the last feature of a sample adds an argmax scan over the sum ram
// and hands the beat to the output register
// rst is synchronous; it clears sums, counters and num_classes (to 10)
// a stalled m_axis holds the next result after the scan, and input stays closed until it is taken
module linear_classifier_accuracy
  import lca_pkg::*;
  #(
    parameter int MAX_CLASSES  = MAX_CLASSES_DEF,
    parameter int MAX_FEATURES = MAX_FEATURES_DEF
  )
  (
    input  logic                   clk,
    input  logic                   rst,
    input  logic                   cfg_wen,
    input  logic [NCLS_W-1:0]      cfg_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // class_index, feature_index, value, label
    input  logic                   s_axis_tuser,   // action
    input  logic                   s_axis_tlast,   // last_feature
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // predicted_class, is_correct, correct_count,
                                                   // sample_count, pad
  );

  localparam int CW    = $clog2(MAX_CLASSES);
  localparam int NW    = $clog2(MAX_CLASSES + 1);
  localparam int DEPTH = MAX_CLASSES * MAX_FEATURES;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] FSTEP = AW'(MAX_FEATURES);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MAC   = 6'b000010,
    ST_DRAIN = 6'b000100,
    ST_SCAN  = 6'b001000,
    ST_SCANW = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t state;

  logic [CLASS_W-1:0]        in_cls;
  logic [FEAT_W-1:0]         in_feat;
  logic signed [VALUE_W-1:0] in_val;
  logic [CLASS_W-1:0]        in_label;
  logic                      s_accept;
  logic                      load_ok;
  logic                      feat_ok;
  logic [AW-1:0]             load_addr;
  logic [NW-1:0]             n_eff;

  logic [NCLS_W-1:0]         num_classes;
  logic [NW-1:0]             n_q;
  logic signed [VALUE_W-1:0] feat_val;
  logic [CLASS_W-1:0]        label_q;
  logic                      last_q;
  logic [CW-1:0]             cls_cnt;
  logic                      cls_last;
  logic [AW-1:0]             waddr;

  logic                      p1_v;
  logic                      p2_v;
  logic                      q1_v;
  logic [CW-1:0]             p1_cls;
  logic [CW-1:0]             p2_cls;
  logic [MAX_CLASSES-1:0]    sum_valid;

  logic signed [VALUE_W-1:0] w_rdata;
  logic [SUM_W-1:0]          s_rdata;
  logic signed [SUM_W-1:0]   sum_rd;
  logic signed [SUM_W-1:0]   sum_new;

  logic signed [SUM_W-1:0]   best_val;
  logic [CW-1:0]             best_cls;
  logic                      correct;
  logic [CNT_W-1:0]          correct_total;
  logic [CNT_W-1:0]          samples_total;
  logic [CNT_W-1:0]          correct_next;
  logic [CNT_W-1:0]          samples_next;
  logic                      out_fire;
  logic [OUT_TDATA_W-1:0]    out_data;

  assign in_cls   = s_axis_tdata[3:0];
  assign in_feat  = s_axis_tdata[11:4];
  assign in_val   = $signed(s_axis_tdata[27:12]);
  assign in_label = s_axis_tdata[31:28];

  assign s_axis_tready = (state == ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  assign load_ok   = (int'(in_cls) < MAX_CLASSES) && (int'(in_feat) < MAX_FEATURES);
  assign feat_ok   = (int'(in_feat) < MAX_FEATURES);
  assign load_addr = AW'(int'(in_cls) * MAX_FEATURES + int'(in_feat));

  always_comb begin
    if (num_classes == '0) begin
      n_eff = NW'(1);
    end else if (int'(num_classes) > MAX_CLASSES) begin
      n_eff = NW'(MAX_CLASSES);
    end else begin
      n_eff = NW'(num_classes);
    end
  end

  assign cls_last = (NW'(cls_cnt) + NW'(1)) == n_q;

  lca_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_weight_ram (
    .clk   (clk),
    .we    (s_accept && (s_axis_tuser == ACT_LOAD) && load_ok),
    .waddr (load_addr),
    .wdata (in_val),
    .raddr (waddr),
    .rdata (w_rdata)
  );

  lca_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_CLASSES)
  ) u_sum_ram (
    .clk   (clk),
    .we    (p2_v),
    .waddr (p2_cls),
    .wdata (sum_new),
    .raddr (cls_cnt),
    .rdata (s_rdata)
  );

  // a class not written since the last sample reads as zero
  assign sum_rd = sum_valid[p1_cls] ? $signed(s_rdata) : '0;

  lca_mac u_mac (
    .clk     (clk),
    .en      (p1_v),
    .weight  (w_rdata),
    .feature (feat_val),
    .sum_in  (sum_rd),
    .sum_out (sum_new)
  );

  assign correct      = (int'(best_cls) == int'(label_q));
  assign samples_next = (samples_total == '1) ? samples_total : samples_total + CNT_W'(1);
  assign correct_next = !correct ? correct_total :
                        (correct_total == '1) ? correct_total : correct_total + CNT_W'(1);
  assign out_fire     = (state == ST_DONE) && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      p1_v          <= 1'b0;
      p2_v          <= 1'b0;
      q1_v          <= 1'b0;
      m_axis_tvalid <= 1'b0;
      sum_valid     <= '0;
      correct_total <= '0;
      samples_total <= '0;
      num_classes   <= NUM_CLASSES_RESET;
    end else begin
      if (cfg_wen) begin
        num_classes <= cfg_wdata;
      end
      p1_v <= (state == ST_MAC);
      q1_v <= (state == ST_SCAN);
      p2_v <= p1_v;
      if (p2_v) begin
        sum_valid[p2_cls] <= 1'b1;
      end
      if (out_fire) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_accept && (s_axis_tuser == ACT_SAMPLE)) begin
            if (feat_ok) begin
              state <= ST_MAC;
            end else if (s_axis_tlast) begin
              state <= ST_SCAN;
            end
          end
        end
        ST_MAC: begin
          if (cls_last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!p1_v) begin
            state <= last_q ? ST_SCAN : ST_IDLE;
          end
        end
        ST_SCAN: begin
          if (cls_last) begin
            state <= ST_SCANW;
          end
        end
        ST_SCANW: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_fire) begin
            samples_total <= samples_next;
            correct_total <= correct_next;
            sum_valid     <= '0;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    p1_cls <= cls_cnt;
    p2_cls <= p1_cls;
    if (s_accept) begin
      feat_val <= in_val;
      label_q  <= in_label;
      last_q   <= s_axis_tlast;
      n_q      <= n_eff;
      cls_cnt  <= '0;
      waddr    <= AW'(in_feat);
    end else if (state == ST_MAC) begin
      cls_cnt <= cls_cnt + CW'(1);
      waddr   <= waddr + FSTEP;
    end else if (state == ST_DRAIN) begin
      cls_cnt <= '0;
    end else if (state == ST_SCAN) begin
      cls_cnt <= cls_cnt + CW'(1);
    end
    if (q1_v && ((p1_cls == '0) || (sum_rd > best_val))) begin
      best_val <= sum_rd;
      best_cls <= p1_cls;
    end
    if (out_fire) begin
      out_data <= {(OUT_TDATA_W - 2*CNT_W - CLASS_W - 1)'(0), samples_next, correct_next,
                   correct, CLASS_W'(best_cls)};
    end
  end

  assign m_axis_tdata = out_data;

endmodule

// ----- hw/rtl/lca_checker.sv -----
module lca_checker
  import lca_pkg::*;
  (
    input logic                   clk,
    input logic                   rst,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   s_axis_tuser,
    input logic                   s_axis_tlast,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
  );

  logic s_beat;

  assign s_beat = s_axis_tvalid && s_axis_tready;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // reset leaves the block ready with no result
  a_reset: assert property (@(posedge clk)
    rst |=> s_axis_tready && !m_axis_tvalid)
    else $error("bad state after reset");

  // the last feature of a sample starts the scan, input closes
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    s_beat && (s_axis_tuser == ACT_SAMPLE) && s_axis_tlast |=> !s_axis_tready)
    else $error("input still open after last feature");

  // a weight load never raises a result
  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    s_beat && (s_axis_tuser == ACT_LOAD) && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result after weight load");

endmodule

bind linear_classifier_accuracy lca_checker u_lca_checker (.*);
